@@ hw/rtl/fr_pkg.sv @@
// ----------------------------------------------------------------------------
// fr_pkg
// Fixed-point formats, constants and side-band records shared by the
// Fresnel reflectance pipeline.
// ----------------------------------------------------------------------------
package fr_pkg;

    localparam int VEC_FRAC_BITS = 14;
    localparam int OUT_FRAC_BITS = 15;
    localparam int IOR_FRAC_BITS = 14;
    localparam int WORK_BITS     = 30;

    localparam int TWO_F = 2 * VEC_FRAC_BITS;
    localparam int C_SH  = WORK_BITS - TWO_F;

    localparam logic [33:0] ONE_2F    = 34'(64'd1 << TWO_F);
    localparam logic [31:0] ONE_30    = 32'(64'd1 << WORK_BITS);
    localparam logic [15:0] IOR_ONE   = 16'(32'd1 << IOR_FRAC_BITS);
    localparam logic [62:0] SQ_ONE    = 63'(64'd1 << 62);
    localparam logic [63:0] OUT_HALF  = 64'(64'd1 << (61 - OUT_FRAC_BITS));
    localparam int          RES_W     = OUT_FRAC_BITS + 2;
    localparam logic [RES_W-1:0] RES_ONE = RES_W'(64'd1 << OUT_FRAC_BITS);

    // geometry carried alongside the cosine and root units
    typedef struct packed {
        logic        tir;
        logic        from_in;
        logic [15:0] etai;
        logic [15:0] etat;
        logic [30:0] c30;
    } fr_geo_t;

    // flags carried alongside the Rs ratio divider
    typedef struct packed {
        logic tir;
        logic from_in;
        logic zero_s;
    } fr_flag_t;

endpackage

@@ hw/rtl/fresnel_reflectance.sv @@
// ----------------------------------------------------------------------------
// fresnel_reflectance
// Throughput: one request per cycle; busy is always low. The depth is set by
// the cosine and ratio dividers and the root unit, one bit per stage each.
// Reset clears only the valid bits; the receiver cannot stall the pipeline.
//
// Unpolarized Fresnel reflectance of a dielectric boundary. Front end forms
// the clamped cosine, swaps indices for rays leaving the material and tests
// for total internal reflection. The transmitted cosine comes from a long
// division and a square root, then both amplitude ratios are divided out,
// squared and averaged into a Q1.15 reflectance.
// ----------------------------------------------------------------------------
module fresnel_reflectance (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] inc_x,
    input  logic signed [15:0] inc_y,
    input  logic signed [15:0] inc_z,
    input  logic signed [15:0] norm_x,
    input  logic signed [15:0] norm_y,
    input  logic signed [15:0] norm_z,
    input  logic        [15:0] medium_index,
    output logic               done,
    output logic        [15:0] reflectance,
    output logic               total_internal,
    output logic               from_inside
);

    import fr_pkg::*;

    // never back-pressure: a new request may enter every cycle
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 1: the three component products of the dot product
    // ------------------------------------------------------------------
    logic               v1_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic        [15:0] ior1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        px_reg   <= inc_x * norm_x;
        py_reg   <= inc_y * norm_y;
        pz_reg   <= inc_z * norm_z;
        // a zero index would divide by zero; treat it as one LSB
        ior1_reg <= (medium_index == 16'd0) ? 16'd1 : medium_index;
    end

    // ------------------------------------------------------------------
    // Stage 2: sum, clamp to +-1.0, pick side, cosine magnitude in Q30
    // ------------------------------------------------------------------
    logic signed [33:0] dot;
    logic        [33:0] dot_mag;
    logic        [33:0] cabs;
    logic               v2_reg, inside2_reg;
    logic        [30:0] c30_2_reg;
    logic        [15:0] ior2_reg;

    always_comb
    begin
        dot     = 34'(px_reg) + 34'(py_reg) + 34'(pz_reg);
        dot_mag = (dot < 34'sd0) ? 34'(-dot) : 34'(dot);
        cabs    = (dot_mag > ONE_2F) ? ONE_2F : dot_mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        inside2_reg <= dot > 34'sd0;
        c30_2_reg   <= 31'(cabs) << C_SH;
        ior2_reg    <= ior1_reg;
    end

    // ------------------------------------------------------------------
    // Stage 3: swap indices, square cosine and indices
    // ------------------------------------------------------------------
    logic [15:0] etai_next, etat_next;
    logic        v3_reg, inside3_reg;
    logic [30:0] c30_3_reg;
    logic [15:0] etai3_reg, etat3_reg;
    logic [61:0] csq3_reg;
    logic [31:0] ei2_3_reg, et2_3_reg;

    always_comb
    begin
        etai_next = inside2_reg ? ior2_reg : IOR_ONE;
        etat_next = inside2_reg ? IOR_ONE : ior2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        inside3_reg <= inside2_reg;
        c30_3_reg   <= c30_2_reg;
        etai3_reg   <= etai_next;
        etat3_reg   <= etat_next;
        csq3_reg    <= 62'(c30_2_reg) * 62'(c30_2_reg);
        ei2_3_reg   <= 32'(etai_next) * 32'(etai_next);
        et2_3_reg   <= 32'(etat_next) * 32'(etat_next);
    end

    // ------------------------------------------------------------------
    // Stage 4: squared sine of the incident angle, Q30
    // ------------------------------------------------------------------
    logic        v4_reg, inside4_reg;
    logic [30:0] c30_4_reg, sin2_4_reg;
    logic [15:0] etai4_reg, etat4_reg;
    logic [31:0] ei2_4_reg, et2_4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        inside4_reg <= inside3_reg;
        c30_4_reg   <= c30_3_reg;
        sin2_4_reg  <= 31'(ONE_30 - csq3_reg[61:30]);
        etai4_reg   <= etai3_reg;
        etat4_reg   <= etat3_reg;
        ei2_4_reg   <= ei2_3_reg;
        et2_4_reg   <= et2_3_reg;
    end

    // ------------------------------------------------------------------
    // Stage 5: etai^2 * sin^2
    // ------------------------------------------------------------------
    logic        v5_reg, inside5_reg;
    logic [30:0] c30_5_reg;
    logic [15:0] etai5_reg, etat5_reg;
    logic [31:0] et2_5_reg;
    logic [62:0] lhs5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        inside5_reg <= inside4_reg;
        c30_5_reg   <= c30_4_reg;
        etai5_reg   <= etai4_reg;
        etat5_reg   <= etat4_reg;
        et2_5_reg   <= et2_4_reg;
        lhs5_reg    <= 63'(ei2_4_reg) * 63'(sin2_4_reg);
    end

    // ------------------------------------------------------------------
    // Stage 6: total internal reflection test, exact
    // ------------------------------------------------------------------
    logic        v6_reg;
    fr_geo_t     geo6_reg;
    logic [31:0] et2_6_reg;
    logic [62:0] lhs6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else
            v6_reg <= v5_reg;
    end

    always_ff @(posedge clk)
    begin
        geo6_reg.tir     <= lhs5_reg >= {1'b0, et2_5_reg, 30'd0};
        geo6_reg.from_in <= inside5_reg;
        geo6_reg.etai    <= etai5_reg;
        geo6_reg.etat    <= etat5_reg;
        geo6_reg.c30     <= c30_5_reg;
        et2_6_reg        <= et2_5_reg;
        lhs6_reg         <= lhs5_reg;
    end

    // ------------------------------------------------------------------
    // Divider: lhs / etat^2. cos^2 t = 1 - ceil(lhs / etat^2) since
    // etat^2 * 2^30 divides exactly. Result is only used without TIR.
    // ------------------------------------------------------------------
    logic        va_valid;
    logic [30:0] va_quo;
    logic [31:0] va_rem;
    fr_geo_t     va_geo;

    fr_div #(
        .NW (63),
        .DW (32),
        .QW (31),
        .SW ($bits(fr_geo_t))
    ) u_div_cos (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v6_reg),
        .num       (lhs6_reg),
        .den       (et2_6_reg),
        .in_side   (geo6_reg),
        .out_valid (va_valid),
        .quo       (va_quo),
        .rem       (va_rem),
        .out_side  (va_geo)
    );

    // ------------------------------------------------------------------
    // Stage 7: squared transmitted cosine, Q30
    // ------------------------------------------------------------------
    logic [31:0] ceil_q;
    logic        v7_reg;
    fr_geo_t     geo7_reg;
    logic [30:0] cos2t7_reg;

    assign ceil_q = 32'(va_quo) + ((va_rem != 32'd0) ? 32'd1 : 32'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v7_reg <= 1'b0;
        else
            v7_reg <= va_valid;
    end

    always_ff @(posedge clk)
    begin
        geo7_reg   <= va_geo;
        // drop the garbage quotient of a reflected-only ray
        cos2t7_reg <= va_geo.tir ? 31'd0 : 31'(ONE_30 - ceil_q);
    end

    // ------------------------------------------------------------------
    // Root: transmitted cosine, Q30
    // ------------------------------------------------------------------
    logic        vs_valid;
    logic [30:0] t30;
    fr_geo_t     vs_geo;

    fr_sqrt #(
        .RW (31),
        .SW ($bits(fr_geo_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v7_reg),
        .radicand  ({1'b0, cos2t7_reg, 30'd0}),
        .in_side   (geo7_reg),
        .out_valid (vs_valid),
        .root      (t30),
        .out_side  (vs_geo)
    );

    // ------------------------------------------------------------------
    // Stage 8: the four index-weighted cosines
    // ------------------------------------------------------------------
    logic        v8_reg, tir8_reg, inside8_reg;
    logic [46:0] ps8_reg, qs8_reg, pp8_reg, qp8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v8_reg <= 1'b0;
        else
            v8_reg <= vs_valid;
    end

    always_ff @(posedge clk)
    begin
        tir8_reg    <= vs_geo.tir;
        inside8_reg <= vs_geo.from_in;
        ps8_reg     <= 47'(vs_geo.etat) * 47'(vs_geo.c30);
        qs8_reg     <= 47'(vs_geo.etai) * 47'(t30);
        pp8_reg     <= 47'(vs_geo.etai) * 47'(vs_geo.c30);
        qp8_reg     <= 47'(vs_geo.etat) * 47'(t30);
    end

    // ------------------------------------------------------------------
    // Stage 9: difference and sum of each pair
    // ------------------------------------------------------------------
    logic        v9_reg, tir9_reg, inside9_reg;
    logic [47:0] dens9_reg, denp9_reg;
    logic [46:0] difs9_reg, difp9_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v9_reg <= 1'b0;
        else
            v9_reg <= v8_reg;
    end

    always_ff @(posedge clk)
    begin
        tir9_reg    <= tir8_reg;
        inside9_reg <= inside8_reg;
        dens9_reg   <= 48'(ps8_reg) + 48'(qs8_reg);
        denp9_reg   <= 48'(pp8_reg) + 48'(qp8_reg);
        difs9_reg   <= (ps8_reg > qs8_reg) ? ps8_reg - qs8_reg : qs8_reg - ps8_reg;
        difp9_reg   <= (pp8_reg > qp8_reg) ? pp8_reg - qp8_reg : qp8_reg - pp8_reg;
    end

    // ------------------------------------------------------------------
    // Stage 10: shift needed to bring each sum under 32 bits
    // ------------------------------------------------------------------
    logic [4:0]  shs_next, shp_next;
    logic        v10_reg, tir10_reg, inside10_reg;
    logic [4:0]  shs10_reg, shp10_reg;
    logic [47:0] dens10_reg, denp10_reg;
    logic [46:0] difs10_reg, difp10_reg;

    always_comb
    begin
        shs_next = 5'd0;
        shp_next = 5'd0;
        for (int i = 32; i < 48; i++)
        begin
            if (dens9_reg[i])
                shs_next = 5'(i - 31);
            if (denp9_reg[i])
                shp_next = 5'(i - 31);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v10_reg <= 1'b0;
        else
            v10_reg <= v9_reg;
    end

    always_ff @(posedge clk)
    begin
        tir10_reg    <= tir9_reg;
        inside10_reg <= inside9_reg;
        shs10_reg    <= shs_next;
        shp10_reg    <= shp_next;
        dens10_reg   <= dens9_reg;
        denp10_reg   <= denp9_reg;
        difs10_reg   <= difs9_reg;
        difp10_reg   <= difp9_reg;
    end

    // ------------------------------------------------------------------
    // Stage 11: apply the shift, clamp the numerator to the denominator
    // ------------------------------------------------------------------
    logic [47:0] dens_sh, denp_sh;
    logic [46:0] difs_sh, difp_sh;
    logic        v11_reg;
    fr_flag_t    flag11_reg;
    logic        zp11_reg;
    logic [31:0] dens11_reg, denp11_reg, difs11_reg, difp11_reg;

    always_comb
    begin
        dens_sh = dens10_reg >> shs10_reg;
        denp_sh = denp10_reg >> shp10_reg;
        difs_sh = difs10_reg >> shs10_reg;
        difp_sh = difp10_reg >> shp10_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v11_reg <= 1'b0;
        else
            v11_reg <= v10_reg;
    end

    always_ff @(posedge clk)
    begin
        flag11_reg.tir     <= tir10_reg;
        flag11_reg.from_in <= inside10_reg;
        flag11_reg.zero_s  <= dens_sh == 48'd0;
        zp11_reg           <= denp_sh == 48'd0;
        dens11_reg         <= dens_sh[31:0];
        denp11_reg         <= denp_sh[31:0];
        difs11_reg         <= (47'(dens_sh) < difs_sh) ? dens_sh[31:0] : difs_sh[31:0];
        difp11_reg         <= (47'(denp_sh) < difp_sh) ? denp_sh[31:0] : difp_sh[31:0];
    end

    // ------------------------------------------------------------------
    // Ratio dividers, Q31 magnitudes of Rs and Rp
    // ------------------------------------------------------------------
    logic        vb_valid, vc_valid;
    logic [31:0] rs_quo, rp_quo;
    logic [31:0] rs_rem, rp_rem;
    fr_flag_t    rs_flag;
    logic        rp_zero;

    fr_div #(
        .NW (63),
        .DW (32),
        .QW (32),
        .SW ($bits(fr_flag_t))
    ) u_div_rs (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v11_reg),
        .num       ({difs11_reg, 31'd0}),
        .den       (dens11_reg),
        .in_side   (flag11_reg),
        .out_valid (vb_valid),
        .quo       (rs_quo),
        .rem       (rs_rem),
        .out_side  (rs_flag)
    );

    fr_div #(
        .NW (63),
        .DW (32),
        .QW (32),
        .SW (1)
    ) u_div_rp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v11_reg),
        .num       ({difp11_reg, 31'd0}),
        .den       (denp11_reg),
        .in_side   (zp11_reg),
        .out_valid (vc_valid),
        .quo       (rp_quo),
        .rem       (rp_rem),
        .out_side  (rp_zero)
    );

    // ------------------------------------------------------------------
    // Stage 12: square each ratio to Q62; a zero sum counts as 1.0
    // ------------------------------------------------------------------
    logic [63:0] rs_sq, rp_sq;
    logic        v12_reg, tir12_reg, inside12_reg;
    logic [62:0] rs12_reg, rp12_reg;

    assign rs_sq = 64'(rs_quo) * 64'(rs_quo);
    assign rp_sq = 64'(rp_quo) * 64'(rp_quo);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v12_reg <= 1'b0;
        else
            v12_reg <= vb_valid & vc_valid;
    end

    always_ff @(posedge clk)
    begin
        tir12_reg    <= rs_flag.tir;
        inside12_reg <= rs_flag.from_in;
        rs12_reg     <= rs_flag.zero_s ? SQ_ONE : rs_sq[62:0];
        rp12_reg     <= rp_zero ? SQ_ONE : rp_sq[62:0];
    end

    // ------------------------------------------------------------------
    // Stage 13: mean, round half up to the output format, clamp
    // ------------------------------------------------------------------
    logic [63:0]      kr_sum;
    logic [63:0]      kr_rnd;
    logic [RES_W-1:0] res_raw;
    logic [RES_W-1:0] res_sel;
    logic             done_reg;
    logic [15:0]      refl_reg;
    logic             tir_out_reg, inside_out_reg;

    always_comb
    begin
        kr_sum  = 64'(rs12_reg) + 64'(rp12_reg);
        kr_rnd  = {1'b0, kr_sum[63:1]} + OUT_HALF;
        res_raw = kr_rnd[63:62-OUT_FRAC_BITS];
        if (tir12_reg || res_raw > RES_ONE)
            res_sel = RES_ONE;
        else
            res_sel = res_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v12_reg;
    end

    always_ff @(posedge clk)
    begin
        refl_reg       <= 16'(res_sel);
        tir_out_reg    <= tir12_reg;
        inside_out_reg <= inside12_reg;
    end

    assign done           = done_reg;
    assign reflectance    = refl_reg;
    assign total_internal = tir_out_reg;
    assign from_inside    = inside_out_reg;

endmodule

@@ hw/rtl/fr_div.sv @@
// ----------------------------------------------------------------------------
// fr_div
// Pipelined restoring divider, one quotient bit per stage. Expects
// num < den * 2**QW; returns floor quotient and remainder.
// ----------------------------------------------------------------------------
module fr_div #(
    parameter int NW = 63,
    parameter int DW = 32,
    parameter int QW = 32,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic [DW-1:0] rem,
    output logic [SW-1:0] out_side
);

    logic          v_reg   [QW];
    logic [DW-1:0] rem_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [QW-1:0] nl_reg  [QW];
    logic [QW-1:0] q_reg   [QW];
    logic [SW-1:0] sd_reg  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic          v_src;
        logic [DW-1:0] rem_src;
        logic [DW-1:0] den_src;
        logic [QW-1:0] nl_src;
        logic [QW-1:0] q_src;
        logic [SW-1:0] sd_src;
        logic [DW:0]   trial;
        logic          take;

        if (k == 0) begin : g_head
            assign v_src   = in_valid;
            assign rem_src = DW'(num[NW-1:QW]);
            assign den_src = den;
            assign nl_src  = num[QW-1:0];
            assign q_src   = '0;
            assign sd_src  = in_side;
        end else begin : g_body
            assign v_src   = v_reg[k-1];
            assign rem_src = rem_reg[k-1];
            assign den_src = den_reg[k-1];
            assign nl_src  = nl_reg[k-1];
            assign q_src   = q_reg[k-1];
            assign sd_src  = sd_reg[k-1];
        end

        // bring down the next dividend bit, subtract when it fits
        assign trial = {rem_src, nl_src[QW-1]};
        assign take  = trial >= {1'b0, den_src};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else
                v_reg[k] <= v_src;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= take ? DW'(trial - {1'b0, den_src}) : DW'(trial);
            den_reg[k] <= den_src;
            nl_reg[k]  <= {nl_src[QW-2:0], 1'b0};
            q_reg[k]   <= {q_src[QW-2:0], take};
            sd_reg[k]  <= sd_src;
        end
    end

    assign out_valid = v_reg[QW-1];
    assign quo       = q_reg[QW-1];
    assign rem       = rem_reg[QW-1];
    assign out_side  = sd_reg[QW-1];

endmodule

@@ hw/rtl/fr_sqrt.sv @@
// ----------------------------------------------------------------------------
// fr_sqrt
// Pipelined floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
module fr_sqrt #(
    parameter int RW = 31,
    parameter int SW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [2*RW-1:0] radicand,
    input  logic [SW-1:0]   in_side,
    output logic            out_valid,
    output logic [RW-1:0]   root,
    output logic [SW-1:0]   out_side
);

    logic            v_reg    [RW];
    logic [RW+1:0]   rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [2*RW-1:0] rad_reg  [RW];
    logic [SW-1:0]   sd_reg   [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic            v_src;
        logic [RW+1:0]   rem_src;
        logic [RW-1:0]   root_src;
        logic [2*RW-1:0] rad_src;
        logic [SW-1:0]   sd_src;
        logic [RW+3:0]   cur;
        logic [RW+3:0]   trial;
        logic            take;

        if (k == 0) begin : g_head
            assign v_src    = in_valid;
            assign rem_src  = '0;
            assign root_src = '0;
            assign rad_src  = radicand;
            assign sd_src   = in_side;
        end else begin : g_body
            assign v_src    = v_reg[k-1];
            assign rem_src  = rem_reg[k-1];
            assign root_src = root_reg[k-1];
            assign rad_src  = rad_reg[k-1];
            assign sd_src   = sd_reg[k-1];
        end

        // shift in the next bit pair and test 4*root + 1
        assign cur   = {rem_src, rad_src[2*RW-1:2*RW-2]};
        assign trial = (RW+4)'({root_src, 2'b01});
        assign take  = cur >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else
                v_reg[k] <= v_src;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= take ? (RW+2)'(cur - trial) : (RW+2)'(cur);
            root_reg[k] <= {root_src[RW-2:0], take};
            rad_reg[k]  <= {rad_src[2*RW-3:0], 2'b00};
            sd_reg[k]   <= sd_src;
        end
    end

    assign out_valid = v_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign out_side  = sd_reg[RW-1];

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Fresnel reflectance pipeline. Sends directed
// geometry corners, then random hits in bursts, predicts the reflectance
// with a 64-bit integer model and checks every done strobe in order.
// ----------------------------------------------------------------------------
module tb_top;

    import fr_pkg::*;

    // one ray-surface hit
    typedef struct {
        logic signed [15:0] ix, iy, iz;
        logic signed [15:0] nx, ny, nz;
        logic        [15:0] ior;
    } hit_t;

    // expected shading result
    typedef struct {
        logic [15:0] refl;
        logic        tir;
        logic        from_in;
    } shade_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] inc_x, inc_y, inc_z;
    logic signed [15:0] norm_x, norm_y, norm_z;
    logic        [15:0] medium_index;
    logic               done;
    logic        [15:0] reflectance;
    logic               total_internal;
    logic               from_inside;

    hit_t   pending_hits[$];
    shade_t expected_shades[$];
    int     error_count = 0;
    bit     stim_done   = 0;
    bit     drain_hold  = 0;
    int     gap_left    = 0;
    int     burst_left  = 0;

    fresnel_reflectance u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .inc_x          (inc_x),
        .inc_y          (inc_y),
        .inc_z          (inc_z),
        .norm_x         (norm_x),
        .norm_y         (norm_y),
        .norm_z         (norm_z),
        .medium_index   (medium_index),
        .done           (done),
        .reflectance    (reflectance),
        .total_internal (total_internal),
        .from_inside    (from_inside)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // floor square root, bit by bit
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // squared amplitude ratio (p - q) / (p + q), Q62
    function automatic logic [63:0] amp_ratio_sq(input logic [63:0] p, input logic [63:0] q);
        logic [63:0] dif;
        logic [63:0] den;
        logic [63:0] r;
        dif = (p > q) ? p - q : q - p;
        den = p + q;
        if (den == 0) return 64'd1 << 62;
        while (den >= (64'd1 << 32))
        begin
            den = den >> 1;
            dif = dif >> 1;
        end
        if (den == 0) return 64'd1 << 62;
        if (dif > den) dif = den;
        r = (dif << 31) / den;
        return r * r;
    endfunction

    function automatic shade_t predict_shade(input hit_t h);
        shade_t      s;
        logic signed [63:0] dot;
        logic [63:0] cabs, c30, one30, ior, etai, etat, ei2, et2;
        logic [63:0] sin2i, lhs, rhs, cos2t, t30, rs, rp, kr, res;
        one30 = 64'd1 << WORK_BITS;
        dot = 64'(h.ix) * 64'(h.nx) + 64'(h.iy) * 64'(h.ny) + 64'(h.iz) * 64'(h.nz);
        if (dot > (64'sd1 <<< TWO_F)) dot = 64'sd1 <<< TWO_F;
        if (dot < -(64'sd1 <<< TWO_F)) dot = -(64'sd1 <<< TWO_F);
        s.from_in = dot > 0;
        cabs = (dot < 0) ? -dot : dot;
        c30 = cabs << (WORK_BITS - TWO_F);
        if (c30 > one30) c30 = one30;
        ior = {48'd0, h.ior};
        if (ior == 0) ior = 1;
        etai = s.from_in ? ior : 64'd1 << IOR_FRAC_BITS;
        etat = s.from_in ? 64'd1 << IOR_FRAC_BITS : ior;
        ei2 = etai * etai;
        et2 = etat * etat;
        sin2i = one30 - ((c30 * c30) >> WORK_BITS);
        lhs = ei2 * sin2i;
        rhs = et2 * one30;
        if (lhs >= rhs)
        begin
            s.refl = 16'd1 << OUT_FRAC_BITS;
            s.tir  = 1'b1;
            return s;
        end
        cos2t = (rhs - lhs) / et2;
        if (cos2t > one30) cos2t = one30;
        t30 = floor_sqrt(cos2t << WORK_BITS);
        rs = amp_ratio_sq(etat * c30, etai * t30);
        rp = amp_ratio_sq(etai * c30, etat * t30);
        kr = (rs + rp) >> 1;
        res = (kr + (64'd1 << (61 - OUT_FRAC_BITS))) >> (62 - OUT_FRAC_BITS);
        if (res > (64'd1 << OUT_FRAC_BITS)) res = 64'd1 << OUT_FRAC_BITS;
        s.refl = res[15:0];
        s.tir  = 1'b0;
        return s;
    endfunction

    function automatic hit_t make_hit(input int ix, iy, iz, nx, ny, nz, ior);
        hit_t h;
        h.ix = ix; h.iy = iy; h.iz = iz;
        h.nx = nx; h.ny = ny; h.nz = nz;
        h.ior = ior;
        return h;
    endfunction

    // random component over the full port range, usually within +-1.0
    function automatic int rand_comp();
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 65535) - 32768;
        return $urandom_range(0, 32768) - 16384;
    endfunction

    // mostly roughly unit vectors from random angle pairs, else random components
    function automatic hit_t rand_hit();
        hit_t h;
        real a, b, c, d;
        a = $urandom_range(0, 62831) / 10000.0;
        b = $urandom_range(0, 31415) / 10000.0;
        c = $urandom_range(0, 62831) / 10000.0;
        d = $urandom_range(0, 31415) / 10000.0;
        if ($urandom_range(0, 4) == 0)
        begin
            h = make_hit(rand_comp(), rand_comp(), rand_comp(),
                         rand_comp(), rand_comp(), rand_comp(), $urandom_range(0, 65535));
        end
        else
        begin
            h.ix = $rtoi(16384.0 * $sin(b) * $cos(a));
            h.iy = $rtoi(16384.0 * $sin(b) * $sin(a));
            h.iz = $rtoi(16384.0 * $cos(b));
            h.nx = $rtoi(16384.0 * $sin(d) * $cos(c));
            h.ny = $rtoi(16384.0 * $sin(d) * $sin(c));
            h.nz = $rtoi(16384.0 * $cos(d));
            h.ior = $urandom_range(16384, 65535);
        end
        return h;
    endfunction

    // driver: pop a request at the falling edge, honor bursts and gaps
    always @(negedge clk)
    begin
        if (start && !busy && rst_n)
            ;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (drain_hold || pending_hits.size() == 0 || gap_left > 0)
        begin
            start <= 1'b0;
            if (gap_left > 0) gap_left <= gap_left - 1;
        end
        else
        begin
            hit_t h;
            h = pending_hits.pop_front();
            inc_x <= h.ix; inc_y <= h.iy; inc_z <= h.iz;
            norm_x <= h.nx; norm_y <= h.ny; norm_z <= h.nz;
            medium_index <= h.ior;
            expected_shades.push_back(predict_shade(h));
            start <= 1'b1;
            // busy stays low, so every raised start is a taken request
            if (burst_left > 0)
                burst_left <= burst_left - 1;
            else
            begin
                burst_left <= $urandom_range(0, 40);
                gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
        end
    end

    // monitor: compare each done strobe with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            shade_t e;
            if (expected_shades.size() == 0)
            begin
                $display("%0t: unexpected result refl=%0d tir=%0b inside=%0b",
                         $realtime, reflectance, total_internal, from_inside);
                error_count++;
            end
            else
            begin
                e = expected_shades.pop_front();
                if (reflectance !== e.refl)
                begin
                    $display("%0t: reflectance expected %0d actual %0d",
                             $realtime, e.refl, reflectance);
                    error_count++;
                end
                if (total_internal !== e.tir)
                begin
                    $display("%0t: total_internal expected %0b actual %0b",
                             $realtime, e.tir, total_internal);
                    error_count++;
                end
                if (from_inside !== e.from_in)
                begin
                    $display("%0t: from_inside expected %0b actual %0b",
                             $realtime, e.from_in, from_inside);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #200000;
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        int n;
        rst_n = 1'b0;
        start = 1'b0;
        inc_x = 0; inc_y = 0; inc_z = 0;
        norm_x = 0; norm_y = 0; norm_z = 0;
        medium_index = 0;

        // directed corners: head-on from both sides, grazing, all-ones index,
        // zero index, total internal reflection, overlong vectors, extremes
        pending_hits.push_back(make_hit(0, 0, -16384, 0, 0, 16384, 24576));
        pending_hits.push_back(make_hit(0, 0, 16384, 0, 0, 16384, 24576));
        pending_hits.push_back(make_hit(16384, 0, 0, 0, 0, 16384, 24576));
        pending_hits.push_back(make_hit(16384, 0, 0, 0, 0, 16384, 16384));
        pending_hits.push_back(make_hit(0, 0, -16384, 0, 0, 16384, 0));
        pending_hits.push_back(make_hit(0, 0, 16384, 0, 0, 16384, 0));
        pending_hits.push_back(make_hit(11585, 0, 11585, 0, 0, 16384, 65535));
        pending_hits.push_back(make_hit(16000, 0, 3000, 0, 0, 16384, 24576));
        pending_hits.push_back(make_hit(-16384, 0, -1, 0, 0, 16384, 65535));
        pending_hits.push_back(make_hit(32767, 32767, 32767, 32767, 32767, 32767, 65535));
        pending_hits.push_back(make_hit(-32768, -32768, -32768, 32767, 32767, 32767, 1));
        pending_hits.push_back(make_hit(-32768, -32768, -32768, -32768, -32768, -32768, 32768));
        pending_hits.push_back(make_hit(0, 0, 0, 0, 0, 0, 21845));
        pending_hits.push_back(make_hit(-16384, 16384, -16384, 16384, -16384, 16384, 16384));
        pending_hits.push_back(make_hit(5461, -5461, 16000, -3000, 2000, 16000, 43690));
        pending_hits.push_back(make_hit(1, 0, 0, 1, 0, 0, 65535));
        pending_hits.push_back(make_hit(-1, 0, 0, 1, 0, 0, 65535));
        for (n = 0; n < 1850; n++)
            pending_hits.push_back(rand_hit());

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // pause the sender once mid-run until the pipeline drains
        wait (pending_hits.size() < 900);
        @(negedge clk);
        drain_hold = 1'b1;
        wait (expected_shades.size() == 0);
        @(negedge clk);
        drain_hold = 1'b0;

        wait (pending_hits.size() == 0);
        wait (expected_shades.size() == 0);
        repeat (120) @(posedge clk);
        if (error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
